/* rtl/core/bdl_pkg.sv */
// Package for the bounded deque: sizes, operation and status codes,
// transfer structs and ring index arithmetic. Depends on nothing.
`timescale 1ns / 1ps

package bdl_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int VAL_W     = 32;
  localparam int KIND_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int OUT_CNT_W = 7;

  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_VIEW       = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [VAL_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] element_value;
    logic [STATUS_W-1:0]     status;
    logic [OUT_CNT_W-1:0]    element_count;
    logic                    last_result;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  // Reduces a sum below twice the depth to a ring position.
  function automatic logic [IDX_W-1:0] wrap_sum(input logic [IDX_W:0] s);
    logic [IDX_W:0] lim;
    lim = (IDX_W + 1)'(DEPTH);
    if (s >= lim) begin
      wrap_sum = IDX_W'(s - lim);
    end else begin
      wrap_sum = IDX_W'(s);
    end
  endfunction

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] p);
    if (p == IDX_W'(DEPTH - 1)) begin
      ring_inc = '0;
    end else begin
      ring_inc = IDX_W'(p + 1'b1);
    end
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] p);
    if (p == '0) begin
      ring_dec = IDX_W'(DEPTH - 1);
    end else begin
      ring_dec = IDX_W'(p - 1'b1);
    end
  endfunction

endpackage

/* rtl/core/bdl_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. Depends on nothing.
`timescale 1ns / 1ps

module bdl_ram #(
  parameter int WIDTH     = 32,
  parameter int NUM_WORDS = 16,
  parameter int AW        = $clog2(NUM_WORDS)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [NUM_WORDS];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/bdl_ctrl.sv */
// Deque sequencer: ring pointers, operation decode, view walk and the
// result register. Depends on bdl_pkg; drives the element RAM.
`timescale 1ns / 1ps

module bdl_ctrl
  import bdl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  in_item_t         in_item,
  output logic             busy,
  output ram_req_t         ram_req,
  input  logic [VAL_W-1:0] ram_rdata,
  output logic             out_valid,
  output out_item_t        out_item
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_POP  = 3'b010,
    ST_VIEW = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [CNT_W-1:0] view_idx_r, view_idx_nxt;
  logic [IDX_W-1:0] view_ptr_r, view_ptr_nxt;
  out_item_t        out_item_r, out_item_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             full;
  logic             empty;
  logic [IDX_W-1:0] back_pos;
  logic [IDX_W-1:0] last_pos;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] front_inc;
  logic [IDX_W-1:0] view_ptr_inc;
  logic [CNT_W-1:0] held_inc;
  logic [CNT_W-1:0] held_dec;
  logic [CNT_W-1:0] view_idx_inc;

  assign full         = (held_r == CNT_W'(DEPTH));
  assign empty        = (held_r == '0);
  assign held_inc     = CNT_W'(held_r + 1'b1);
  assign held_dec     = CNT_W'(held_r - 1'b1);
  assign view_idx_inc = CNT_W'(view_idx_r + 1'b1);
  assign back_pos     = wrap_sum({1'b0, front_r} + (IDX_W + 1)'(held_r));
  assign last_pos     = wrap_sum({1'b0, front_r} + (IDX_W + 1)'(held_dec));
  assign front_dec    = ring_dec(front_r);
  assign front_inc    = ring_inc(front_r);
  assign view_ptr_inc = ring_inc(view_ptr_r);

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    held_nxt      = held_r;
    view_idx_nxt  = view_idx_r;
    view_ptr_nxt  = view_ptr_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = back_pos;
    ram_req.wdata = in_item.push_value;
    ram_req.raddr = front_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{'0, STATUS_OK, OUT_CNT_W'(held_r), 1'b1};
          case (in_item.kind)
            KIND_PUSH_BACK: begin
              if (full) begin
                out_item_nxt.status = STATUS_FULL;
              end else begin
                ram_req.we                 = 1'b1;
                held_nxt                   = held_inc;
                out_item_nxt.element_count = OUT_CNT_W'(held_inc);
              end
            end
            KIND_PUSH_FRONT: begin
              if (full) begin
                out_item_nxt.status = STATUS_FULL;
              end else begin
                ram_req.we                 = 1'b1;
                ram_req.waddr              = front_dec;
                front_nxt                  = front_dec;
                held_nxt                   = held_inc;
                out_item_nxt.element_count = OUT_CNT_W'(held_inc);
              end
            end
            KIND_POP_FRONT: begin
              if (empty) begin
                out_item_nxt.status = STATUS_EMPTY;
              end else begin
                front_nxt     = front_inc;
                held_nxt      = held_dec;
                state_nxt     = ST_POP;
                out_valid_nxt = 1'b0;
              end
            end
            KIND_POP_BACK: begin
              if (empty) begin
                out_item_nxt.status = STATUS_EMPTY;
              end else begin
                ram_req.raddr = last_pos;
                held_nxt      = held_dec;
                state_nxt     = ST_POP;
                out_valid_nxt = 1'b0;
              end
            end
            KIND_VIEW: begin
              if (empty) begin
                out_item_nxt.status = STATUS_EMPTY;
              end else begin
                view_ptr_nxt  = front_r;
                view_idx_nxt  = '0;
                state_nxt     = ST_VIEW;
                out_valid_nxt = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{ram_rdata, STATUS_OK, OUT_CNT_W'(held_r), 1'b1};
        state_nxt     = ST_IDLE;
      end
      ST_VIEW: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{ram_rdata, STATUS_OK, OUT_CNT_W'(held_r),
                          (view_idx_inc == held_r)};
        ram_req.raddr = view_ptr_inc;
        view_ptr_nxt  = view_ptr_inc;
        view_idx_nxt  = view_idx_inc;
        if (view_idx_inc == held_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    view_idx_r <= view_idx_nxt;
    view_ptr_r <= view_ptr_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/core/bounded_deque_list_unit.sv */
// Bounded double-ended queue of signed 32-bit values held in a ring RAM.
// Depends on bdl_pkg, bdl_ctrl and bdl_ram.
// A push result is registered and appears in the cycle after the transfer; a pop result
// passes the RAM read register and then the result register. A pop makes one RAM read,
// a view reads one element per cycle from the RAM read port; busy is high meanwhile.
// Synchronous active-low reset empties the queue; results cannot be stalled.
`timescale 1ns / 1ps

module bounded_deque_list_unit
  import bdl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_item
);

  ram_req_t         ram_req;
  logic [VAL_W-1:0] ram_rdata;

  bdl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  bdl_ram #(
    .WIDTH     (VAL_W),
    .NUM_WORDS (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

/* bench/deque_result_monitor.sv */
// Result monitor for the bounded deque: it follows every transfer on both channels,
// keeps its own copy of the ring and compares each result with the predicted one.
// Depends on bdl_pkg for the transfer structs, the operation codes and the sizes.
`timescale 1ns / 1ps

module deque_result_monitor
  import bdl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        fail_count,
  output int        outstanding
);

  logic signed [VAL_W-1:0] ring_mem [DEPTH];
  int                      front_pos;
  int                      held;
  out_item_t               awaited_results [$];

  function automatic out_item_t result_of(input logic signed [VAL_W-1:0] value,
                                          input logic [STATUS_W-1:0] status,
                                          input int count, input logic last);
    out_item_t r;
    r.element_value = value;
    r.status        = status;
    r.element_count = OUT_CNT_W'(count);
    r.last_result   = last;
    return r;
  endfunction

  task automatic predict_deque_op(input in_item_t it);
    int slot;
    case (it.kind)
      KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
        if (held == DEPTH) begin
          awaited_results.push_back(result_of('0, STATUS_FULL, held, 1'b1));
        end else begin
          if (it.kind == KIND_PUSH_FRONT) begin
            front_pos = (front_pos + DEPTH - 1) % DEPTH;
            slot      = front_pos;
          end else begin
            slot = (front_pos + held) % DEPTH;
          end
          ring_mem[IDX_W'(slot)] = it.push_value;
          held++;
          awaited_results.push_back(result_of('0, STATUS_OK, held, 1'b1));
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (held == 0) begin
          awaited_results.push_back(result_of('0, STATUS_EMPTY, 0, 1'b1));
        end else begin
          if (it.kind == KIND_POP_FRONT) begin
            slot      = front_pos;
            front_pos = (front_pos + 1) % DEPTH;
          end else begin
            slot = (front_pos + held - 1) % DEPTH;
          end
          held--;
          awaited_results.push_back(result_of(ring_mem[IDX_W'(slot)], STATUS_OK, held,
                                              1'b1));
        end
      end
      KIND_VIEW: begin
        if (held == 0) begin
          awaited_results.push_back(result_of('0, STATUS_EMPTY, 0, 1'b1));
        end else begin
          for (int i = 0; i < held; i++) begin
            awaited_results.push_back(result_of(ring_mem[IDX_W'((front_pos + i) % DEPTH)],
                                                STATUS_OK, held, i == held - 1));
          end
        end
      end
      default: begin
        awaited_results.push_back(result_of('0, STATUS_OK, held, 1'b1));
      end
    endcase
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (awaited_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%t: unexpected result: value %0d status %0d count %0d last %0b",
                 $realtime, got.element_value, got.status, got.element_count,
                 got.last_result);
      end
    end else begin
      want = awaited_results.pop_front();
      if (got.element_value !== want.element_value || got.status !== want.status ||
          got.element_count !== want.element_count ||
          got.last_result !== want.last_result) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%t: mismatch: expected value %0d status %0d count %0d last %0b",
                   $realtime, want.element_value, want.status, want.element_count,
                   want.last_result);
          $display("%t:           actual   value %0d status %0d count %0d last %0b",
                   $realtime, got.element_value, got.status, got.element_count,
                   got.last_result);
        end
      end
    end
  endtask

  initial fail_count = 0;

  // A result is checked before the transfer of the same edge is predicted, since
  // no result can come from an item accepted at that very edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      front_pos = 0;
      held      = 0;
      awaited_results.delete();
    end else begin
      if (out_valid === 1'b1) begin
        check_result(out_item);
      end
      if (start === 1'b1 && busy === 1'b0) begin
        predict_deque_op(in_item);
      end
    end
    outstanding <= awaited_results.size();
  end

endmodule

/* bench/tb.sv */
// Top of the deque testbench: clock, reset and stimulus for bounded_deque_list_unit,
// with the verdict taken from the result monitor beside it.
// Depends on bdl_pkg, bounded_deque_list_unit and deque_result_monitor.
`timescale 1ns / 1ps

module tb;
  import bdl_pkg::*;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  logic      out_valid;
  in_item_t  in_item;
  out_item_t out_item;
  int        fail_count;
  int        outstanding;

  bounded_deque_list_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  deque_result_monitor u_mon (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [KIND_W-1:0] pick_kind(input mix_t mix);
    int r;
    int push_lim;
    int pop_lim;
    r        = $urandom_range(99);
    push_lim = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 20 : 40;
    pop_lim  = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 80 : 75;
    if (r < push_lim) begin
      return $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
    end else if (r < pop_lim) begin
      return $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK;
    end else if (r < 93) begin
      return KIND_VIEW;
    end else begin
      return KIND_VIEW + KIND_W'($urandom_range(1, 3));
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return {1'b0, {(VAL_W-1){1'b1}}};
      1: return {1'b1, {(VAL_W-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Holds the item on the port until the block takes it; an optional idle
  // stretch comes first.
  task automatic send_op(input logic [KIND_W-1:0] kind,
                         input logic signed [VAL_W-1:0] value, input bit may_idle);
    if (may_idle && $urandom_range(99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_item.kind       <= kind;
    in_item.push_value <= value;
    start              <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    mix_t mix;
    start   <= 1'b0;
    in_item <= '0;
    rst_n   <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_op(KIND_VIEW, pick_value(), 1'b1);
    send_op(KIND_POP_FRONT, pick_value(), 1'b1);
    send_op(KIND_POP_BACK, pick_value(), 1'b1);
    for (int k = KIND_VIEW + 1; k < 2 ** KIND_W; k++) begin
      send_op(KIND_W'(k), pick_value(), 1'b1);
    end
    send_op(KIND_PUSH_BACK, {1'b0, {(VAL_W-1){1'b1}}}, 1'b1);
    send_op(KIND_PUSH_FRONT, {1'b1, {(VAL_W-1){1'b0}}}, 1'b1);
    send_op(KIND_PUSH_BACK, '1, 1'b1);
    send_op(KIND_PUSH_FRONT, '0, 1'b1);
    send_op(KIND_VIEW, pick_value(), 1'b1);
    send_op(KIND_POP_BACK, pick_value(), 1'b1);
    send_op(KIND_POP_FRONT, pick_value(), 1'b1);
    send_op(KIND_VIEW, pick_value(), 1'b1);

    for (int n = 0; n < 260; n++) begin
      mix = mix_t'((n / 40) % 3);
      send_op(pick_kind(mix), pick_value(), !(n >= 100 && n < 170));
    end
    start <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
